FILE: rtl/core/fcr_pkg.sv
// fcr_pkg: shared types and constants for the filled circle rasterizer.
// Used by fcr_datapath, fcr_ctrl and filled_circle_raster_top.
`default_nettype none

package fcr_pkg;

	// Default canvas coordinate width
	localparam int COORD_WIDTH_DEF = 13;

	// Configuration register geometry
	localparam int CFG_W        = 13;
	localparam int CFG_ADDR_W   = 3;
	localparam int PIX_W        = 12;
	localparam logic [CFG_W-1:0] SCREEN_LIMIT      = 13'd4096;
	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1920;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd1080;

	// Register index (word address bit 2)
	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} fcr_reg_t;

	// Input transaction kind
	typedef enum logic {
		MODE_CLICK = 1'b0,
		MODE_TICK  = 1'b1
	} fcr_mode_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_DX,
		ST_SQ_DY,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_SQ_R,
		ST_LOAD,
		ST_SCAN
	} fcr_state_t;

	// Shared multiplier operand select
	typedef enum logic [1:0] {
		MUL_DX,
		MUL_DY,
		MUL_R
	} fcr_mul_sel_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic         cap_center;
		logic         cap_delta;
		logic         mul_en;
		fcr_mul_sel_t mul_sel;
		logic         acc_en;
		logic         root_start;
		logic         root_latch;
		logic         load_scan;
		logic         step;
	} fcr_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic root_busy;
		logic scan_last;
	} fcr_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fcr_isqrt.sv
// fcr_isqrt: digit-serial integer square root, one result bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module fcr_isqrt #(
	parameter int COORD_WIDTH = 13
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [2*COORD_WIDTH+1:0] opnd,
	output logic                     busy,
	output logic [COORD_WIDTH:0]     root
);

	localparam int OPW = 2*COORD_WIDTH + 2;
	localparam int RTW = COORD_WIDTH + 1;
	localparam int RMW = RTW + 3;
	localparam int CNW = $clog2(RTW);

	logic           busy_q;
	logic [CNW-1:0] cnt_q;
	logic [OPW-1:0] opnd_q;
	logic [RMW-1:0] rem_q;
	logic [RTW-1:0] root_q;

	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic           fits;

	// One restoring step: bring down two operand bits, try root*4+1
	always_comb begin
		rem_sh = {rem_q[RMW-3:0], opnd_q[OPW-1:OPW-2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(RTW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder, root and operand shift register
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= opnd;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= {opnd_q[OPW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RTW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RTW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: rtl/core/fcr_datapath.sv
// fcr_datapath: center/delta capture, shared squarer, radius, scan counters,
// disk and screen test, and the result register. Uses fcr_pkg and fcr_isqrt.
`default_nettype none

module fcr_datapath
	import fcr_pkg::*;
#(
	parameter int COORD_WIDTH = 13
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fcr_cmd_t                     cmd,
	output fcr_sts_t                     sts,
	input  wire  signed [COORD_WIDTH-1:0] click_x,
	input  wire  signed [COORD_WIDTH-1:0] click_y,
	input  wire  [CFG_W-1:0]             screen_width,
	input  wire  [CFG_W-1:0]             screen_height,
	output logic                         pixel_valid,
	output logic [PIX_W-1:0]             pixel_x,
	output logic [PIX_W-1:0]             pixel_y,
	output logic                         last
);

	localparam int CW  = COORD_WIDTH;
	localparam int MW  = CW + 1;          // magnitude / radius width
	localparam int PRW = 2*CW + 2;        // square width
	localparam int SW  = CW + 2;          // scan offset width
	localparam int PW  = (CW + 3 > 14) ? CW + 3 : 14;  // position width

	logic signed [CW-1:0]  center_x_q, center_y_q;
	logic [MW-1:0]         dx_abs_q, dy_abs_q;
	logic [PRW-1:0]        prod_q, acc_q;
	logic [MW-1:0]         radius_q;
	logic [PRW-1:0]        r2_q, x2_q, y2_q;
	logic signed [SW-1:0]  scan_x_q, scan_y_q;

	logic signed [MW-1:0]  dx, dy;
	logic [MW-1:0]         mul_a;
	logic [PRW-1:0]        d2;
	logic                  root_busy;
	logic [MW-1:0]         root;
	logic signed [SW-1:0]  radius_s, neg_radius;
	logic signed [PRW:0]   x2_inc, y2_inc;
	logic [PRW:0]          dist2;
	logic signed [PW-1:0]  px, py;
	logic [PW-1:0]         wlim, hlim;
	logic                  in_disk, in_screen, hit, at_last, row_end;

	// Click offsets from the center, as magnitudes
	always_comb begin
		dx = $signed({click_x[CW-1], click_x}) - $signed({center_x_q[CW-1], center_x_q});
		dy = $signed({click_y[CW-1], click_y}) - $signed({center_y_q[CW-1], center_y_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_center) begin
			center_x_q <= click_x;
			center_y_q <= click_y;
		end
		if (cmd.cap_delta) begin
			dx_abs_q <= dx[MW-1] ? MW'(-dx) : MW'(dx);
			dy_abs_q <= dy[MW-1] ? MW'(-dy) : MW'(dy);
		end
	end

	// Shared squarer with registered product
	always_comb begin
		case (cmd.mul_sel)
			MUL_DX:  mul_a = dx_abs_q;
			MUL_DY:  mul_a = dy_abs_q;
			MUL_R:   mul_a = root;
			default: mul_a = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PRW'(mul_a) * PRW'(mul_a);
		end
		if (cmd.acc_en) begin
			acc_q <= prod_q;
		end
	end

	// Squared distance; always fits since each term is below 2^(2*CW)
	assign d2 = PRW'(acc_q + prod_q);

	fcr_isqrt #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.root_start),
		.opnd  (d2),
		.busy  (root_busy),
		.root  (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.root_latch) begin
			radius_q <= root;
		end
	end

	assign radius_s   = $signed({1'b0, radius_q});
	assign neg_radius = -radius_s;

	// Incremental squares: (v+1)^2 = v^2 + 2v + 1
	always_comb begin
		x2_inc = $signed({1'b0, x2_q}) + $signed({{CW{scan_x_q[SW-1]}}, scan_x_q, 1'b1});
		y2_inc = $signed({1'b0, y2_q}) + $signed({{CW{scan_y_q[SW-1]}}, scan_y_q, 1'b1});
		row_end = (scan_x_q == radius_s);
		at_last = row_end && (scan_y_q == radius_s);
	end

	// Scan position counters, row-major from (-r,-r) to (+r,+r)
	always_ff @(posedge clk) begin
		if (cmd.load_scan) begin
			r2_q     <= prod_q;
			x2_q     <= prod_q;
			y2_q     <= prod_q;
			scan_x_q <= neg_radius;
			scan_y_q <= neg_radius;
		end else if (cmd.step && !at_last) begin
			if (row_end) begin
				scan_x_q <= neg_radius;
				x2_q     <= r2_q;
				scan_y_q <= scan_y_q + 1'b1;
				y2_q     <= y2_inc[PRW-1:0];
			end else begin
				scan_x_q <= scan_x_q + 1'b1;
				x2_q     <= x2_inc[PRW-1:0];
			end
		end
	end

	// Disk and screen test for the current position
	always_comb begin
		dist2   = {1'b0, x2_q} + {1'b0, y2_q};
		in_disk = (dist2 <= {1'b0, r2_q});
		px   = PW'(center_x_q) + PW'(scan_x_q);
		py   = PW'(center_y_q) + PW'(scan_y_q);
		wlim = PW'((screen_width  > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width);
		hlim = PW'((screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height);
		in_screen = !px[PW-1] && ($unsigned(px) < wlim)
		         && !py[PW-1] && ($unsigned(py) < hlim);
		hit = in_disk && in_screen;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pixel_valid <= hit;
			pixel_x     <= hit ? px[PIX_W-1:0] : '0;
			pixel_y     <= hit ? py[PIX_W-1:0] : '0;
			last        <= at_last;
		end
	end

	assign sts.root_busy = root_busy;
	assign sts.scan_last = at_last;

endmodule

`default_nettype wire

FILE: rtl/core/fcr_ctrl.sv
// fcr_ctrl: sequencer for click handling, radius setup and the pixel scan,
// plus the input/output handshakes. Uses fcr_pkg.
`default_nettype none

module fcr_ctrl
	import fcr_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      in_valid,
	output logic     in_stall,
	input  wire      mode,
	output logic     out_valid,
	input  wire      out_stall,
	output fcr_cmd_t cmd,
	input  fcr_sts_t sts
);

	fcr_state_t state_q, state_d;
	logic       awaiting_q, awaiting_d;
	logic       out_valid_q, out_valid_d;
	logic       out_free, in_acc, is_tick;

	// State, pending-center flag and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			awaiting_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			awaiting_q  <= awaiting_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		awaiting_d = awaiting_q;
		cmd        = '0;
		cmd.mul_sel = MUL_DX;
		out_free   = !(out_valid_q && out_stall);
		in_stall   = 1'b1;
		is_tick    = (fcr_mode_t'(mode) == MODE_TICK);
		in_acc     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_stall = !out_free;
				in_acc   = in_valid && out_free;
				// ticks while idle are dropped
				if (in_acc && !is_tick) begin
					if (!awaiting_q) begin
						cmd.cap_center = 1'b1;
						awaiting_d     = 1'b1;
					end else begin
						cmd.cap_delta = 1'b1;
						awaiting_d    = 1'b0;
						state_d       = ST_SQ_DX;
					end
				end
			end
			ST_SQ_DX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DX;
				state_d     = ST_SQ_DY;
			end
			ST_SQ_DY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DY;
				cmd.acc_en  = 1'b1;
				state_d     = ST_ROOT_GO;
			end
			ST_ROOT_GO: begin
				cmd.root_start = 1'b1;
				state_d        = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (!sts.root_busy) begin
					state_d = ST_SQ_R;
				end
			end
			ST_SQ_R: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_R;
				cmd.root_latch = 1'b1;
				state_d        = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_scan = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				in_stall = !out_free;
				in_acc   = in_valid && out_free;
				// clicks during a scan are dropped
				if (in_acc && is_tick) begin
					cmd.step = 1'b1;
					if (sts.scan_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		out_valid_d = cmd.step || (out_valid_q && out_stall);
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/filled_circle_raster_top.sv
// filled_circle_raster_top: top level with the configuration registers.
// Uses fcr_pkg, fcr_ctrl and fcr_datapath.
`default_nettype none

// Filled-disk rasterizer. A click (mode 0) with no circle pending stores the
// center; the next click sets the radius to floor(sqrt(dx^2 + dy^2)) and
// starts a scan over the square -r..+r (rows outer, columns inner). Each tick
// (mode 1) during a scan yields one result: pixel_valid with the screen
// coordinate when the position is inside both the disk and the screen
// (clipped to min(register, 4096)), else zeros; last marks the final
// position. Clicks during a scan and ticks with no scan are consumed without
// a result. Ticks stream at one per clock while the output is drained.
// After the second click the input stalls during radius setup, most of it the
// square-root unit that resolves one root bit per cycle. Registers: screen_width
// at 0x0, screen_height at 0x4, 13 bits each; write only while idle.
module filled_circle_raster_top
	import fcr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [CFG_ADDR_W-1:0]        paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// input channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          mode,
	input  wire  signed [COORD_WIDTH-1:0] click_x,
	input  wire  signed [COORD_WIDTH-1:0] click_y,
	// output channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         pixel_valid,
	output logic [PIX_W-1:0]             pixel_x,
	output logic [PIX_W-1:0]             pixel_y,
	output logic                         last
);

	logic [CFG_W-1:0] screen_width_q, screen_height_q;
	logic             cfg_wr;
	fcr_reg_t         reg_sel;
	fcr_cmd_t         cmd;
	fcr_sts_t         sts;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = fcr_reg_t'(paddr[2]);

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[CFG_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_sel)
			REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			default:           prdata = '0;
		endcase
	end

	fcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	fcr_datapath #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.click_x      (click_x),
		.click_y      (click_y),
		.screen_width (screen_width_q),
		.screen_height(screen_height_q),
		.pixel_valid  (pixel_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last         (last)
	);

endmodule

`default_nettype wire
